// ===== rtl/mfb_pkg.sv =====
// Package for the monochrome framebuffer rectangle fill block.
// Holds command codes, decoded-op types and fixed field widths; no dependencies.
`default_nettype none

package mfb_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_STORE_BYTES   = 1024;

    // Fixed widths of the beat fields
    localparam int KIND_W  = 2;
    localparam int COORD_W = 8;
    localparam int INDEX_W = 10;
    localparam int BYTE_W  = 8;

    // Page index width (screen height is at most 128 rows, 16 pages)
    localparam int PAGE_W  = 4;
    // Linear byte address width, wide enough to compare against 4096
    localparam int LIN_W   = 13;

    // Command kind codes on the input channel
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Decoded operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind             op;
        logic [COORD_W-1:0]   col_first;
        logic [COORD_W-1:0]   col_last;
        logic [PAGE_W-1:0]    page_first;
        logic [PAGE_W-1:0]    page_last;
        logic [2:0]           row_lo;     // first row bit within first page
        logic [2:0]           row_hi;     // last row bit within last page
        logic                 pixel_on;
        logic [INDEX_W-1:0]   index;
    } t_op;

    // Status from the back to the front
    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== rtl/mfb_ifs.sv =====
// Channel interfaces for the framebuffer block: command input and result output.
// Depends on mfb_pkg for field widths.
`default_nettype none

interface mfb_cmd_if
    import mfb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic               pixel_on;
    logic [INDEX_W-1:0] byte_index;

    modport source (
        output valid, kind, rect_x, rect_y, rect_width, rect_height, pixel_on, byte_index,
        input  ready
    );
    modport sink (
        input  valid, kind, rect_x, rect_y, rect_width, rect_height, pixel_on, byte_index,
        output ready
    );
endinterface

interface mfb_res_if
    import mfb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;

    modport source (output valid, read_byte, input ready);
    modport sink   (input valid, read_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mfb_front.sv =====
// Front end: accepts command beats, clips rectangles and decodes them into ops.
// Depends on mfb_pkg and mfb_cmd_if.
`default_nettype none

module mfb_front
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
    mfb_cmd_if.sink    i_cmd,
    input  t_back_stat i_stat,
    input  logic       i_full,
    output logic       o_push,
    output t_op        o_op
);

    logic [COORD_W:0] x_end;
    logic [COORD_W:0] y_end;
    logic [COORD_W:0] x_end_c;
    logic [COORD_W:0] y_end_c;
    logic [COORD_W:0] row_last;
    logic             fill_empty;
    logic             idx_ok;

    assign i_cmd.ready = !i_full && !i_stat.init_busy;
    assign o_push      = i_cmd.valid && i_cmd.ready;

    // Clip the far edges to the screen; coordinates never wrap
    always_comb begin
        x_end   = (COORD_W+1)'(i_cmd.rect_x) + (COORD_W+1)'(i_cmd.rect_width);
        y_end   = (COORD_W+1)'(i_cmd.rect_y) + (COORD_W+1)'(i_cmd.rect_height);
        x_end_c = (x_end > (COORD_W+1)'(SCREEN_WIDTH)) ? (COORD_W+1)'(SCREEN_WIDTH) : x_end;
        y_end_c = (y_end > (COORD_W+1)'(SCREEN_HEIGHT)) ? (COORD_W+1)'(SCREEN_HEIGHT) : y_end;
        row_last   = y_end_c - (COORD_W+1)'(1);
        fill_empty = ((COORD_W+1)'(i_cmd.rect_x) >= x_end_c) ||
                     ((COORD_W+1)'(i_cmd.rect_y) >= y_end_c);
        idx_ok     = LIN_W'(i_cmd.byte_index) < LIN_W'(STORE_BYTES);
    end

    always_comb begin
        o_op.col_first  = i_cmd.rect_x;
        o_op.col_last   = COORD_W'(x_end_c - (COORD_W+1)'(1));
        o_op.page_first = i_cmd.rect_y[PAGE_W+2:3];
        o_op.page_last  = row_last[PAGE_W+2:3];
        o_op.row_lo     = i_cmd.rect_y[2:0];
        o_op.row_hi     = row_last[2:0];
        o_op.pixel_on   = i_cmd.pixel_on;
        o_op.index      = i_cmd.byte_index;
        unique case (i_cmd.kind)
            KIND_CLEAR: o_op.op = OP_CLEAR;
            KIND_FILL:  o_op.op = fill_empty ? OP_NOP : OP_FILL;
            KIND_READ:  o_op.op = idx_ok ? OP_READ : OP_NOP;
            default:    o_op.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mfb_queue.sv =====
// Two-entry op queue between the front end and the back end.
// Depends on mfb_pkg for the op type.
`default_nettype none

module mfb_queue
    import mfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_head,
    output logic o_empty
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_op;
    end

endmodule

`default_nettype wire

// ===== rtl/mfb_back.sv =====
// Back end: frame memory, clear sweep, rectangle read-modify-write walk, byte read.
// Depends on mfb_pkg and mfb_res_if.
`default_nettype none

module mfb_back
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
    parameter int STORE_BYTES  = DEF_STORE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output t_back_stat  o_stat,
    mfb_res_if.source   o_res
);

    localparam int AW = $clog2(STORE_BYTES);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_READ  = 6'b001000,
        S_RD    = 6'b010000,
        S_WR    = 6'b100000
    } t_state;

    logic [BYTE_W-1:0]  mem [STORE_BYTES];

    t_state             r_state,     n_state;
    logic [AW-1:0]      r_clr,       n_clr;
    t_op                r_op,        n_op;
    logic [COORD_W-1:0] r_col,       n_col;
    logic [PAGE_W-1:0]  r_page,      n_page;
    logic [LIN_W-1:0]   r_base,      n_base;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte,  n_out_byte;
    logic [BYTE_W-1:0]  r_rdata;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [LIN_W-1:0]   lin;
    logic               lin_ok;
    logic [2:0]         bit_lo;
    logic [2:0]         bit_hi;
    logic [BYTE_W-1:0]  mask;
    logic               out_free;

    assign o_res.valid     = r_out_valid;
    assign o_res.read_byte = r_out_byte;
    assign o_stat.init_busy = (r_state == S_INIT);

    assign out_free = !r_out_valid || o_res.ready;
    assign lin      = r_base + LIN_W'(r_col);
    assign lin_ok   = lin < LIN_W'(STORE_BYTES);

    // Row bits covered within the current page
    always_comb begin
        bit_lo = (r_page == r_op.page_first) ? r_op.row_lo : 3'd0;
        bit_hi = (r_page == r_op.page_last)  ? r_op.row_hi : 3'd7;
        for (int b = 0; b < BYTE_W; b++) begin
            mask[b] = (3'(b) >= bit_lo) && (3'(b) <= bit_hi);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_col       = r_col;
        n_page      = r_page;
        n_base      = r_base;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_byte  = r_out_byte;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(lin);
        mem_wdata   = '0;
        mem_raddr   = AW'(i_head.index);

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                    if (r_state == S_CLEAR) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                    end
                end
            end
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        OP_NOP: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = '0;
                        end
                        OP_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_FILL: begin
                            n_op    = i_head;
                            n_col   = i_head.col_first;
                            n_page  = i_head.page_first;
                            n_base  = LIN_W'(i_head.page_first) * LIN_W'(SCREEN_WIDTH);
                            n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_byte  = r_rdata;
                n_state     = S_IDLE;
            end
            S_RD, S_WR: begin
                mem_raddr = AW'(lin);
                if (r_state == S_RD && lin_ok) begin
                    n_state = S_WR;
                end else begin
                    if (r_state == S_WR) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_op.pixel_on ? (r_rdata | mask) : (r_rdata & ~mask);
                    end
                    // Step to the next byte of the rectangle
                    n_state = S_RD;
                    if (r_col == r_op.col_last) begin
                        if (r_page == r_op.page_last) begin
                            n_state     = S_IDLE;
                            n_out_valid = 1'b1;
                            n_out_byte  = '0;
                        end else begin
                            n_page = r_page + PAGE_W'(1);
                            n_base = r_base + LIN_W'(SCREEN_WIDTH);
                            n_col  = r_op.col_first;
                        end
                    end else begin
                        n_col = r_col + COORD_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_col      <= n_col;
        r_page     <= n_page;
        r_base     <= n_base;
        r_out_byte <= n_out_byte;
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/monochrome_framebuffer_rect_fill.sv =====
// Page-organized one-bit framebuffer (default 128x64, eight pages of 128 column
// bytes) with clear, clipped rectangle fill and single-byte readout. Every command
// beat yields exactly one result beat; read_byte carries the stored byte for a
// read and zero for everything else. Steps per command in the back end, once it
// takes the op: clear writes one byte per cycle across the whole store; a fill
// reads, then writes, each covered byte inside the store (on the single frame
// memory) and steps past each covered byte beyond it without a write; a read
// does one registered memory read, then offers the byte; a clipped-away fill, an
// out-of-range read or an unused kind is answered with zero from the idle state.
// Rate is set by the read-modify-write on the frame memory port. After reset a
// clearing pass writes zero to every byte of the store, with cmd ready held low.
// A two-entry queue sits between the front end and the back end, so commands are
// taken while an earlier one is still walking the store or its result is waiting.
// Depends on mfb_pkg, mfb_ifs, mfb_front, mfb_queue and mfb_back.
`default_nettype none

module monochrome_framebuffer_rect_fill
    import mfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfb_cmd_if.sink    i_cmd,
    mfb_res_if.source  o_res
);

    t_op        front_op;
    logic       push;
    logic       full;
    t_op        head_op;
    logic       empty;
    logic       pop;
    t_back_stat stat;

    // Decode and clip; ready only when the queue has room and init is done
    mfb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STORE_BYTES   (STORE_BYTES)
    ) u_front (
        .i_cmd  (i_cmd),
        .i_stat (stat),
        .i_full (full),
        .o_push (push),
        .o_op   (front_op)
    );

    // Decoded ops, in order
    mfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_empty (empty)
    );

    // Executes ops against the frame memory and owns the result register
    mfb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .STORE_BYTES  (STORE_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_op),
        .i_empty (empty),
        .o_pop   (pop),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/mfb_checker.sv =====
// Port-level checker for the framebuffer block, bound to the top level.
// No package dependency; watches the channel handshakes only.
`default_nettype none

module mfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_res_byte
);

    logic [2:0] r_outstanding;
    logic       cmd_beat;
    logic       res_beat;

    assign cmd_beat = i_cmd_valid && i_cmd_ready;
    assign res_beat = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 3'(cmd_beat) - 3'(res_beat);
        end
    end

    // Result beat holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_byte))
        else $error("result beat dropped or changed while stalled");

    // No result without a command in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_outstanding != 3'd0)
        else $error("result beat with no outstanding command");

    // Queue plus one op in the back bounds commands in flight
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 3'd3)
        else $error("too many commands in flight");

    // Clearing pass after reset holds off commands
    a_init_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_cmd_ready)
        else $error("command taken during clearing pass");

endmodule

bind monochrome_framebuffer_rect_fill mfb_checker u_mfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_byte  (o_res.read_byte)
);

`default_nettype wire

// ===== sim/monochrome_framebuffer_rect_fill_tb.sv =====
// Self-checking bench for monochrome_framebuffer_rect_fill: directed and random commands.
// A shadow frame store predicts every result beat; checks it in order against the DUT.
// Depends on mfb_pkg, mfb_ifs and the RTL top level.
`timescale 1ns / 1ps

module monochrome_framebuffer_rect_fill_tb;
    import mfb_pkg::*;

    // Command code with no meaning; the block must ignore it and answer zero
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 450;
    localparam int NUM_PHASES       = 4;
    // Long receiver hold-off: starts once this many commands have gone in
    localparam int HOLD_AT_CMD      = 40;
    localparam int HOLD_CYCLES      = 1500;
    // Stall limit sits well above the post-reset clear, a full-screen fill and the hold-off
    localparam int STALL_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 20;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic               on;
        logic [INDEX_W-1:0] idx;
    } t_cmd_beat;

    logic i_clk;
    logic i_rst_n;

    mfb_cmd_if cmd_ch ();
    mfb_res_if res_ch ();

    monochrome_framebuffer_rect_fill dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the frame store, zero after reset like the block's
    logic [BYTE_W-1:0] shadow_frame [0:DEF_STORE_BYTES-1] = '{default: '0};

    t_cmd_beat         pending_cmds [$];    // waiting to be offered
    logic [BYTE_W-1:0] expected_bytes [$];  // predicted result beats, oldest first

    int sender_idle_pct;
    int receiver_stall_pct;
    int accepted_cmds;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int hold_left;
    bit hold_done;

    // Last filled corner, used to aim reads where pixels actually changed
    int last_fill_x;
    int last_fill_y;

    t_cmd_beat         next_beat;
    t_cmd_beat         seen_beat;
    logic [BYTE_W-1:0] want_byte;

    // ------------------------------------------------------------------
    // Prediction: apply one command to the shadow store, return read_byte
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] frame_apply(input t_cmd_beat c);
        int col_end;
        int row_end;
        int row;
        int col;
        int addr;
        logic [BYTE_W-1:0] result;
        result = '0;
        case (c.kind)
            KIND_CLEAR: begin
                for (addr = 0; addr < DEF_STORE_BYTES; addr++)
                    shadow_frame[addr] = '0;
            end
            KIND_FILL: begin
                // Coordinates are plain integers here: no wrap past 255,
                // anything off the right or bottom edge is clipped.
                col_end = int'(c.x) + int'(c.w);
                row_end = int'(c.y) + int'(c.h);
                if (col_end > DEF_SCREEN_WIDTH)
                    col_end = DEF_SCREEN_WIDTH;
                if (row_end > DEF_SCREEN_HEIGHT)
                    row_end = DEF_SCREEN_HEIGHT;
                for (row = int'(c.y); row < row_end; row++) begin
                    for (col = int'(c.x); col < col_end; col++) begin
                        addr = (row / 8) * DEF_SCREEN_WIDTH + col;
                        if (addr < DEF_STORE_BYTES)
                            shadow_frame[addr][row % 8] = c.on;
                    end
                end
            end
            KIND_READ: begin
                if (int'(c.idx) < DEF_STORE_BYTES)
                    result = shadow_frame[c.idx];
            end
            default: ;  // unused kind: store untouched, result zero
        endcase
        return result;
    endfunction

    function automatic t_cmd_beat make_cmd(input logic [KIND_W-1:0] kind,
                                           input int x, input int y,
                                           input int w, input int h,
                                           input bit on, input int idx);
        t_cmd_beat c;
        c.kind = kind;
        c.x    = x[COORD_W-1:0];
        c.y    = y[COORD_W-1:0];
        c.w    = w[COORD_W-1:0];
        c.h    = h[COORD_W-1:0];
        c.on   = on;
        c.idx  = idx[INDEX_W-1:0];
        return c;
    endfunction

    // Random command. Every field starts fully random so idle fields toggle too;
    // fills are mostly small rectangles near the screen, some fully random.
    function automatic t_cmd_beat random_command();
        t_cmd_beat c;
        int pick;
        int idx;
        c.kind = KIND_W'($urandom_range(3, 0));
        c.x    = COORD_W'($urandom);
        c.y    = COORD_W'($urandom);
        c.w    = COORD_W'($urandom);
        c.h    = COORD_W'($urandom);
        c.on   = 1'($urandom);
        c.idx  = INDEX_W'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 2) begin
            c.kind = KIND_CLEAR;
        end else if (pick < 5) begin
            c.kind = KIND_UNUSED;
        end else if (pick < 50) begin
            c.kind = KIND_READ;
            // half the reads land on the last filled area
            if ($urandom_range(1, 0) == 1) begin
                idx = ((last_fill_y / 8 + $urandom_range(1, 0)) % 8) * DEF_SCREEN_WIDTH
                      + (last_fill_x + $urandom_range(15, 0)) % DEF_SCREEN_WIDTH;
                c.idx = idx[INDEX_W-1:0];
            end
        end else begin
            c.kind = KIND_FILL;
            if ($urandom_range(99, 0) < 85) begin
                c.x = COORD_W'($urandom_range(DEF_SCREEN_WIDTH + 7, 0));
                c.y = COORD_W'($urandom_range(DEF_SCREEN_HEIGHT + 7, 0));
                c.w = COORD_W'($urandom_range(16, 0));
                c.h = COORD_W'($urandom_range(16, 0));
            end
            last_fill_x = int'(c.x);
            last_fill_y = int'(c.y);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Command driver: a new beat only once the previous one is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid       <= 1'b0;
            cmd_ch.kind        <= KIND_CLEAR;
            cmd_ch.rect_x      <= '0;
            cmd_ch.rect_y      <= '0;
            cmd_ch.rect_width  <= '0;
            cmd_ch.rect_height <= '0;
            cmd_ch.pixel_on    <= 1'b0;
            cmd_ch.byte_index  <= '0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                next_beat           = pending_cmds.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.kind        <= next_beat.kind;
                cmd_ch.rect_x      <= next_beat.x;
                cmd_ch.rect_y      <= next_beat.y;
                cmd_ch.rect_width  <= next_beat.w;
                cmd_ch.rect_height <= next_beat.h;
                cmd_ch.pixel_on    <= next_beat.on;
                cmd_ch.byte_index  <= next_beat.idx;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off so the
    // two-entry queue fills and command ready drops while beats are offered
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (!hold_done && accepted_cmds == HOLD_AT_CMD) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats first, then predict for a new command.
    // The result of a command taken at this edge cannot show up at it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accepted_cmds <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %02h",
                             $time, res_ch.read_byte);
                    mismatch_count++;
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (res_ch.read_byte !== want_byte) begin
                        $display("%0t: read_byte mismatch, expected %02h, got %02h",
                                 $time, want_byte, res_ch.read_byte);
                        mismatch_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                seen_beat.kind = cmd_ch.kind;
                seen_beat.x    = cmd_ch.rect_x;
                seen_beat.y    = cmd_ch.rect_y;
                seen_beat.w    = cmd_ch.rect_width;
                seen_beat.h    = cmd_ch.rect_height;
                seen_beat.on   = cmd_ch.pixel_on;
                seen_beat.idx  = cmd_ch.byte_index;
                expected_bytes.push_back(frame_apply(seen_beat));
                accepted_cmds <= accepted_cmds + 1;
            end
        end
    end

    // Watchdog: any beat on either channel counts as progress
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        last_fill_x        = 0;
        last_fill_y        = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: store zero after reset, whole-screen fill with clipping
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_FILL,   0,   0, 255, 255, 1,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0, 1023));
        pending_cmds.push_back(make_cmd(KIND_READ, 255, 255, 255, 255, 1,    0));
        // Fully off-screen corner: nothing changes, no wrap to the top left
        pending_cmds.push_back(make_cmd(KIND_FILL, 255, 255, 255, 255, 0, 1023));
        // Zero width and zero height draw nothing
        pending_cmds.push_back(make_cmd(KIND_FILL,  10,  10,   0,   5, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_FILL,  10,  10,   5,   0, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,  138));
        // Clear that runs over the right and bottom edges
        pending_cmds.push_back(make_cmd(KIND_FILL, 120,  60,  20,  10, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0, 1023));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0, 1016));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,  119));
        // Unused kind: no change, zero answer
        pending_cmds.push_back(make_cmd(KIND_UNUSED, 0,   0, 255, 255, 0,  512));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,  512));
        pending_cmds.push_back(make_cmd(KIND_CLEAR, 77,  33,  12,   9, 1,  700));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,  512));
        // Single pixel, then exact screen, then a hollow inner clear
        pending_cmds.push_back(make_cmd(KIND_FILL,   3,   5,   1,   1, 1,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,    3));
        pending_cmds.push_back(make_cmd(KIND_FILL,   0,   0, 128,  64, 1,    0));
        pending_cmds.push_back(make_cmd(KIND_FILL,   1,   1, 126,  62, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,    1));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0,  129));
        pending_cmds.push_back(make_cmd(KIND_FILL, 127,  63,   1,   1, 0,    0));
        pending_cmds.push_back(make_cmd(KIND_READ,   0,   0,   0,   0, 0, 1023));
        // Column past the edge with a row on screen
        pending_cmds.push_back(make_cmd(KIND_FILL, 200,   3,  10,   3, 1,    0));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_cmds.push_back(random_command());
            // Sender goes quiet until every predicted result has come back
            while (pending_cmds.size() != 0 || cmd_ch.valid || expected_bytes.size() != 0)
                @(posedge i_clk);
        end

        // Every command answers with one beat, so a short tail is enough
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_bytes.size());
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mfb_pkg.sv
rtl/mfb_ifs.sv
rtl/mfb_front.sv
rtl/mfb_queue.sv
rtl/mfb_back.sv
rtl/monochrome_framebuffer_rect_fill.sv
rtl/mfb_checker.sv
sim/monochrome_framebuffer_rect_fill_tb.sv
